/* hdl/fha_pkg.sv */
// Shared types, constants and helper functions of the first-fit heap allocator.
`default_nettype none
package fha_pkg;

   localparam int HEAP_WORDS = 4096;
   localparam int HEAP_AW    = $clog2(HEAP_WORDS);
   localparam int IDX_W      = 13;
   localparam int NEED_W     = 14;
   localparam int WORD_W     = 16;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [NEED_W-1:0]  need_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [HEAP_AW-1:0] addr_type;

   localparam idx_type  MIN_WORDS = 13'd5;
   localparam idx_type  MAX_WORDS = 13'd4096;
   localparam word_type LINK_NONE = 16'h0000;

   typedef enum logic [1:0] {
      CMD_INIT    = 2'd0,
      CMD_ALLOC   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [5:0] {
      S_IDLE, S_INIT, S_INIT2, S_INIT3, S_TAG_A, S_TAG_B,
      S_A_RD, S_A_SZ, S_A_NX, S_A_P, S_A_N, S_A_UL, S_A_OK,
      S_SP1, S_SP2, S_SP3, S_SP4, S_SP6,
      S_UL_R, S_UL_P, S_UL_N, S_UL_W1, S_UL_W2,
      S_R_H, S_R_PV, S_R_PF, S_R_PT, S_R_NX, S_R_NF, S_R_NT,
      S_R_L1, S_R_L2, S_R_L3
   } state_type;

   function automatic logic link_ok(input word_type v, input idx_type hw);
      return v[WORD_W-1] && ({1'b0, v[IDX_W-1:0]} + {1'b0, MIN_WORDS} <= {1'b0, hw});
   endfunction

   function automatic word_type size_word(input idx_type w, input logic f);
      return {w, 2'b00, f};
   endfunction

   function automatic word_type link_word(input idx_type i);
      return {3'b100, i};
   endfunction

endpackage
`default_nettype wire

/* hdl/fha_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module fha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

/* hdl/first_fit_heap_allocator_top.sv */
// Top level of the first-fit heap allocator: command sequencer around the heap RAM.
//
// A transaction is taken when start is high and busy is low; req_cmd selects init (0),
// allocate (1) or release (2), code 3 does nothing. Every transaction gives exactly one
// response: rsp_strobe is high for one cycle with rsp_status and rsp_data_addr, and the
// receiver cannot hold it off. The response comes in the cycle after the sequencer ends.
// The heap lives in a 4096 x 16 RAM with a registered read; the sequencer does one RAM
// read or one RAM write per cycle. Init marks the whole heap as one free block and makes
// it the free list; a heap too small for a block leaves the heap size zero and no list.
// An allocation walks the free list, reading the size and next link of each node that
// does not fit; the first block that fits is taken whole, or split if the rest holds at
// least MIN_WORDS. An allocation rejected at the start (zero bytes or an empty free list)
// keeps busy low and answers in the next cycle. An invalid release is ignored; otherwise
// the block is marked free, merged with each free neighbour and put at the list's head.
// Busy stays high for the whole of an operation; the next transaction may start in the
// cycle in which the previous response is shown.
// csr_we writes the heap size in bytes; it is used at the next init.
// Synchronous reset empties the free list, sets the heap size to zero words (every
// allocation fails until an init) and the size register to 32768. The RAM is not cleared.
`default_nettype none
module first_fit_heap_allocator_top
   import fha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [15:0] req_bytes,
   input  wire logic [14:0] req_addr,
   output logic             rsp_strobe,
   output logic             rsp_status,
   output logic [14:0]      rsp_data_addr,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   state_type state_ff, state_in, ret_ff, ret_in;
   logic      [15:0] heap_bytes_ff;
   idx_type   hw_ff, hw_in, head_ff, head_in, cur_ff, cur_in, steps_ff, steps_in;
   logic      head_vld_ff, head_vld_in;
   need_type  need_ff, need_in;
   idx_type   cs_ff, cs_in, b_ff, b_in, bs_ff, bs_in, u_ff, u_in;
   word_type  p_ff, p_in, n_ff, n_in, tv_ff, tv_in;
   addr_type  tb_ff, tb_in, te_ff, te_in;
   logic      rsp_strobe_ff, rsp_status_ff;
   logic [14:0] rsp_data_addr_ff;

   logic      fin, fin_status;
   logic [14:0] fin_data;
   logic      mem_we;
   addr_type  mem_waddr, mem_raddr;
   word_type  mem_wdata, rdata;

   cmd_type   cmd;
   idx_type   rd_cs, hw_calc, rem, nb, bsum, rel_b;
   need_type  need_raw, need_calc;
   logic      rd_flag, alloc_rej, rel_ok, init_small, fit, split;
   logic      h_ok, pf_ok, nx_has, nf_ok, p_ok, n_ok, rd_link_ok;

   fha_ram #(.WIDTH(WORD_W), .DEPTH(HEAP_WORDS)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (rdata)
   );

   assign cmd        = cmd_type'(req_cmd);
   assign rd_cs      = rdata[WORD_W-1:3];
   assign rd_flag    = rdata[0];
   assign need_raw   = {1'b0, req_bytes[15:3]} + NEED_W'(|req_bytes[2:0]) + 14'd4;
   assign need_calc  = (need_raw < {1'b0, MIN_WORDS}) ? {1'b0, MIN_WORDS} : need_raw;
   assign alloc_rej  = (req_bytes == 16'd0) || !head_vld_ff;
   assign rel_b      = IDX_W'(req_addr[14:3]) - 13'd3;
   assign rel_ok     = (req_addr[2:0] == 3'd0) && (req_addr[14:3] >= 12'd3)
                       && ({2'b00, req_addr[14:3]} + 14'd2 <= {1'b0, hw_ff});
   assign hw_calc    = (heap_bytes_ff[15:3] > MAX_WORDS) ? MAX_WORDS : heap_bytes_ff[15:3];
   assign init_small = hw_calc < MIN_WORDS;
   assign fit        = ({1'b0, rd_cs} >= need_ff)
                       && ({1'b0, cur_ff} + {1'b0, rd_cs} <= {1'b0, hw_ff});
   assign rem        = cs_ff - need_ff[IDX_W-1:0];
   assign split      = rem >= MIN_WORDS;
   assign nb         = cur_ff + need_ff[IDX_W-1:0];
   assign bsum       = b_ff + bs_ff;
   assign h_ok       = rd_flag && (rd_cs >= MIN_WORDS)
                       && ({1'b0, b_ff} + {1'b0, rd_cs} <= {1'b0, hw_ff});
   assign pf_ok      = !rd_flag && (rd_cs >= MIN_WORDS) && (rd_cs <= b_ff);
   assign nx_has     = {1'b0, b_ff} + {1'b0, bs_ff} < {1'b0, hw_ff};
   assign nf_ok      = !rd_flag && (rd_cs >= MIN_WORDS)
                       && ({1'b0, bsum} + {1'b0, rd_cs} <= {1'b0, hw_ff});
   assign p_ok       = link_ok(p_ff, hw_ff);
   assign n_ok       = link_ok(n_ff, hw_ff);
   assign rd_link_ok = link_ok(rdata, hw_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (cmd)
                  CMD_INIT:    state_in = S_INIT;
                  CMD_ALLOC:   state_in = alloc_rej ? S_IDLE : S_A_RD;
                  CMD_RELEASE: state_in = rel_ok ? S_R_H : S_IDLE;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_INIT:  state_in = init_small ? S_IDLE : S_TAG_A;
         S_INIT2: state_in = S_INIT3;
         S_INIT3: state_in = S_IDLE;
         S_TAG_A: state_in = S_TAG_B;
         S_TAG_B: state_in = ret_ff;
         S_A_RD:  state_in = (steps_ff >= hw_ff) ? S_IDLE : S_A_SZ;
         S_A_SZ:  state_in = fit ? S_A_P : S_A_NX;
         S_A_NX:  state_in = rd_link_ok ? S_A_RD : S_IDLE;
         S_A_P:   state_in = S_A_N;
         S_A_N:   state_in = split ? S_SP1 : S_TAG_A;
         S_A_UL:  state_in = S_UL_W1;
         S_A_OK:  state_in = S_IDLE;
         S_SP1:   state_in = S_SP2;
         S_SP2:   state_in = S_SP3;
         S_SP3:   state_in = S_SP4;
         S_SP4:   state_in = S_TAG_A;
         S_SP6:   state_in = S_TAG_A;
         S_UL_R:  state_in = S_UL_P;
         S_UL_P:  state_in = S_UL_N;
         S_UL_N:  state_in = S_UL_W1;
         S_UL_W1: state_in = S_UL_W2;
         S_UL_W2: state_in = ret_ff;
         S_R_H:   state_in = h_ok ? S_TAG_A : S_IDLE;
         S_R_PV:  state_in = (b_ff != '0) ? S_R_PF : S_R_NX;
         S_R_PF:  state_in = pf_ok ? S_UL_R : S_R_NX;
         S_R_PT:  state_in = S_TAG_A;
         S_R_NX:  state_in = nx_has ? S_R_NF : S_R_L1;
         S_R_NF:  state_in = nf_ok ? S_UL_R : S_R_L1;
         S_R_NT:  state_in = S_TAG_A;
         S_R_L1:  state_in = S_R_L2;
         S_R_L2:  state_in = S_R_L3;
         S_R_L3:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ret_in      = ret_ff;
      hw_in       = hw_ff;
      head_in     = head_ff;
      head_vld_in = head_vld_ff;
      cur_in      = cur_ff;
      steps_in    = steps_ff;
      need_in     = need_ff;
      cs_in       = cs_ff;
      b_in        = b_ff;
      bs_in       = bs_ff;
      u_in        = u_ff;
      p_in        = p_ff;
      n_in        = n_ff;
      tb_in       = tb_ff;
      te_in       = te_ff;
      tv_in       = tv_ff;
      fin         = 1'b0;
      fin_status  = 1'b0;
      fin_data    = '0;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;
      mem_raddr   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (cmd)
                  CMD_INIT: begin
                  end
                  CMD_ALLOC: begin
                     if (alloc_rej) begin
                        fin        = 1'b1;
                        fin_status = 1'b1;
                     end else begin
                        need_in  = need_calc;
                        cur_in   = head_ff;
                        steps_in = '0;
                     end
                  end
                  CMD_RELEASE: begin
                     if (rel_ok) begin
                        b_in      = rel_b;
                        mem_raddr = HEAP_AW'(rel_b);
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  default: fin = 1'b1;
               endcase
            end
         end
         S_INIT: begin
            head_vld_in = 1'b0;
            head_in     = '0;
            if (init_small) begin
               hw_in = '0;
               fin   = 1'b1;
            end else begin
               hw_in  = hw_calc;
               tb_in  = '0;
               te_in  = HEAP_AW'(hw_calc - 13'd1);
               tv_in  = size_word(hw_calc, 1'b0);
               ret_in = S_INIT2;
            end
         end
         S_INIT2: begin
            mem_we    = 1'b1;
            mem_waddr = HEAP_AW'(1);
            mem_wdata = LINK_NONE;
         end
         S_INIT3: begin
            mem_we      = 1'b1;
            mem_waddr   = HEAP_AW'(2);
            mem_wdata   = LINK_NONE;
            head_in     = '0;
            head_vld_in = 1'b1;
            fin         = 1'b1;
         end
         S_TAG_A: begin
            mem_we    = 1'b1;
            mem_waddr = tb_ff;
            mem_wdata = tv_ff;
         end
         S_TAG_B: begin
            mem_we    = 1'b1;
            mem_waddr = te_ff;
            mem_wdata = tv_ff;
         end
         S_A_RD: begin
            if (steps_ff >= hw_ff) begin
               fin        = 1'b1;
               fin_status = 1'b1;
            end else begin
               mem_raddr = HEAP_AW'(cur_ff);
            end
         end
         S_A_SZ: begin
            cs_in     = rd_cs;
            mem_raddr = fit ? HEAP_AW'(cur_ff + 13'd1) : HEAP_AW'(cur_ff + 13'd2);
         end
         S_A_NX: begin
            if (rd_link_ok) begin
               cur_in   = rdata[IDX_W-1:0];
               steps_in = steps_ff + 13'd1;
            end else begin
               fin        = 1'b1;
               fin_status = 1'b1;
            end
         end
         S_A_P: begin
            p_in      = rdata;
            mem_raddr = HEAP_AW'(cur_ff + 13'd2);
         end
         S_A_N: begin
            n_in = rdata;
            if (!split) begin
               tb_in  = HEAP_AW'(cur_ff);
               te_in  = HEAP_AW'(cur_ff + cs_ff - 13'd1);
               tv_in  = size_word(cs_ff, 1'b1);
               ret_in = S_A_UL;
            end
         end
         S_A_UL: ret_in = S_A_OK;
         S_A_OK: begin
            fin      = 1'b1;
            fin_data = {HEAP_AW'(cur_ff + 13'd3), 3'b000};
         end
         S_SP1: begin
            mem_we    = 1'b1;
            mem_waddr = HEAP_AW'(nb + 13'd1);
            mem_wdata = p_ff;
         end
         S_SP2: begin
            mem_we    = 1'b1;
            mem_waddr = HEAP_AW'(nb + 13'd2);
            mem_wdata = n_ff;
         end
         S_SP3: begin
            mem_we    = n_ok;
            mem_waddr = HEAP_AW'(n_ff[IDX_W-1:0] + 13'd1);
            mem_wdata = link_word(nb);
         end
         S_SP4: begin
            mem_we    = p_ok;
            mem_waddr = HEAP_AW'(p_ff[IDX_W-1:0] + 13'd2);
            mem_wdata = link_word(nb);
            if (!p_ok) begin
               head_in     = nb;
               head_vld_in = 1'b1;
            end
            tb_in  = HEAP_AW'(nb);
            te_in  = HEAP_AW'(nb + rem - 13'd1);
            tv_in  = size_word(rem, 1'b0);
            ret_in = S_SP6;
         end
         S_SP6: begin
            tb_in  = HEAP_AW'(cur_ff);
            te_in  = HEAP_AW'(nb - 13'd1);
            tv_in  = size_word(need_ff[IDX_W-1:0], 1'b1);
            ret_in = S_A_OK;
         end
         S_UL_R: mem_raddr = HEAP_AW'(u_ff + 13'd1);
         S_UL_P: begin
            p_in      = rdata;
            mem_raddr = HEAP_AW'(u_ff + 13'd2);
         end
         S_UL_N: n_in = rdata;
         S_UL_W1: begin
            if (p_ok) begin
               mem_we    = 1'b1;
               mem_waddr = HEAP_AW'(p_ff[IDX_W-1:0] + 13'd2);
               mem_wdata = n_ff;
            end else begin
               head_vld_in = n_ok;
               head_in     = n_ok ? n_ff[IDX_W-1:0] : '0;
            end
         end
         S_UL_W2: begin
            mem_we    = n_ok;
            mem_waddr = HEAP_AW'(n_ff[IDX_W-1:0] + 13'd1);
            mem_wdata = p_ff;
         end
         S_R_H: begin
            if (h_ok) begin
               bs_in  = rd_cs;
               tb_in  = HEAP_AW'(b_ff);
               te_in  = HEAP_AW'(b_ff + rd_cs - 13'd1);
               tv_in  = size_word(rd_cs, 1'b0);
               ret_in = S_R_PV;
            end else begin
               fin = 1'b1;
            end
         end
         S_R_PV: mem_raddr = HEAP_AW'(b_ff - 13'd1);
         S_R_PF: begin
            if (pf_ok) begin
               u_in   = b_ff - rd_cs;
               b_in   = b_ff - rd_cs;
               bs_in  = bs_ff + rd_cs;
               ret_in = S_R_PT;
            end
         end
         S_R_PT, S_R_NT: begin
            tb_in  = HEAP_AW'(b_ff);
            te_in  = HEAP_AW'(bsum - 13'd1);
            tv_in  = size_word(bs_ff, 1'b0);
            ret_in = (state_ff == S_R_PT) ? S_R_NX : S_R_L1;
         end
         S_R_NX: mem_raddr = HEAP_AW'(bsum);
         S_R_NF: begin
            if (nf_ok) begin
               u_in   = bsum;
               bs_in  = bs_ff + rd_cs;
               ret_in = S_R_NT;
            end
         end
         S_R_L1: begin
            mem_we    = 1'b1;
            mem_waddr = HEAP_AW'(b_ff + 13'd1);
            mem_wdata = LINK_NONE;
         end
         S_R_L2: begin
            mem_we    = 1'b1;
            mem_waddr = HEAP_AW'(b_ff + 13'd2);
            mem_wdata = head_vld_ff ? link_word(head_ff) : LINK_NONE;
         end
         S_R_L3: begin
            mem_we      = head_vld_ff;
            mem_waddr   = HEAP_AW'(head_ff + 13'd1);
            mem_wdata   = link_word(b_ff);
            head_in     = b_ff;
            head_vld_in = 1'b1;
            fin         = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         heap_bytes_ff <= 16'd32768;
         hw_ff         <= '0;
         head_ff       <= '0;
         head_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hw_ff         <= hw_in;
         head_ff       <= head_in;
         head_vld_ff   <= head_vld_in;
         rsp_strobe_ff <= fin;
         if (csr_we) begin
            heap_bytes_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      ret_ff           <= ret_in;
      cur_ff           <= cur_in;
      steps_ff         <= steps_in;
      need_ff          <= need_in;
      cs_ff            <= cs_in;
      b_ff             <= b_in;
      bs_ff            <= bs_in;
      u_ff             <= u_in;
      p_ff             <= p_in;
      n_ff             <= n_in;
      tb_ff            <= tb_in;
      te_ff            <= te_in;
      tv_ff            <= tv_in;
      rsp_status_ff    <= fin_status;
      rsp_data_addr_ff <= fin_data;
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_data_addr = rsp_data_addr_ff;

endmodule
`default_nettype wire
